[design/md5_pkg.sv]
// ============================================================================
// md5_pkg
// Types, round constants and helper functions shared by the MD5 hash engine.
// ============================================================================
package md5_pkg;

    // one input word: operation and message byte
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } msg_word_t;

    // one result word: a chaining word and its end marker
    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } digest_word_t;

    // operation codes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // initial chaining vector
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // padding marker byte and first byte position of the length field
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'h3f;

    // per-step additive constants
    function automatic logic [31:0] sine_const(input logic [5:0] step);
        logic [31:0] k;
        case (step)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // rotate amount for a step
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] s;
        case ({step[5:4], step[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by a step
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [7:0] p;
        case (step[5:4])
            2'd0:    p = {2'b00, step};
            2'd1:    p = 8'(5 * step) + 8'd1;
            2'd2:    p = 8'(3 * step) + 8'd5;
            default: p = 8'(7 * step);
        endcase
        return p[3:0];
    endfunction

    // left rotate of a 32-bit word
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] tmp;
        tmp = {x, x} << s;
        return tmp[63:32];
    endfunction

endpackage

[design/md5_hash_engine.sv]
// ============================================================================
// md5_hash_engine
// MD5 digest engine, one message byte per input word, one shared round unit.
// ============================================================================
// Usage
//   msg channel (msg_valid/msg_ready/msg): each word either absorbs one
//   message byte or finishes the message. msg_ready is high only while the
//   engine is idle.
//   digest channel (digest_valid/digest_ready/digest): a finish returns four
//   words h0..h3 in order, last_word set on the fourth.
// Operation
//   an absorb is taken in the idle state; the 64th byte of a block adds one
//   compression: a read state, the steps through the single round unit, an add state.
//   a finish feeds 9..72 padding bytes at one per cycle, with one or two
//   compressions, then presents the digest words. on long messages the rate
//   is bounded by the one-step-per-cycle round unit.
// Reset and stall
//   reset loads the initial vector and clears the byte count; the block
//   buffer holds no reset value. when the receiver stalls, the current
//   digest word is held and no new message word is taken until all four
//   have been delivered, after which the chaining words return to the
//   initial vector.
// ============================================================================
module md5_hash_engine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_ready,
    input  md5_pkg::msg_word_t       msg,
    output logic                     digest_valid,
    input  logic                     digest_ready,
    output md5_pkg::digest_word_t    digest
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_COMP = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] asm_reg, asm_next;
    logic        len_ok_reg, len_ok_next;
    logic        first_reg, first_next;
    logic        fin_reg, fin_next;
    logic        final_reg, final_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] h0_reg, h0_next, h1_reg, h1_next, h2_reg, h2_next, h3_reg, h3_next;

    // message word store and its registered read
    logic [31:0] word_mem [16];
    logic [31:0] w_rd;
    logic [3:0]  rd_addr;
    logic        byte_en;
    logic [7:0]  byte_val;
    logic        word_wr;

    // round unit signals
    logic [31:0] f_val;
    logic [31:0] t_val;
    logic [63:0] len_shift;
    logic [7:0]  pad_byte;

    assign msg_ready    = (state_reg == ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);

    // digest word selection
    always_comb
    begin
        case (idx_reg)
            2'd0:    digest.digest_word = h0_reg;
            2'd1:    digest.digest_word = h1_reg;
            2'd2:    digest.digest_word = h2_reg;
            default: digest.digest_word = h3_reg;
        endcase
        digest.last_word = (idx_reg == 2'd3);
    end

    // padding byte: marker, zeros, then the little-endian bit count
    assign len_shift = len_reg >> {pos_reg[2:0], 3'b000};
    always_comb
    begin
        if (first_reg)
            pad_byte = md5_pkg::PAD_MARK;
        else if (len_ok_reg && (pos_reg >= md5_pkg::LEN_POS))
            pad_byte = len_shift[7:0];
        else
            pad_byte = 8'h00;
    end

    // byte write into the word assembler
    assign byte_en  = ((state_reg == ST_IDLE) && msg_valid &&
                       (msg.operation == md5_pkg::OP_ABSORB)) || (state_reg == ST_PAD);
    assign byte_val = (state_reg == ST_PAD) ? pad_byte : msg.data_byte;
    assign asm_next = byte_en ? {byte_val, asm_reg[31:8]} : asm_reg;
    assign word_wr  = byte_en && (pos_reg[1:0] == 2'd3);
    assign rd_addr  = (state_reg == ST_COMP) ? md5_pkg::msg_index(step_reg + 6'd1) : 4'd0;

    always_ff @(posedge clk)
    begin
        if (word_wr)
            word_mem[pos_reg[5:2]] <= asm_next;
        w_rd <= word_mem[rd_addr];
    end

    // round function and step sum
    always_comb
    begin
        case (step_reg[5:4])
            2'd0:    f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1:    f_val = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val = a_reg + f_val + w_rd + md5_pkg::sine_const(step_reg);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        len_ok_next = len_ok_reg;
        first_next  = first_reg;
        fin_next    = fin_reg;
        final_next  = final_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        h2_next     = h2_reg;
        h3_next     = h3_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.operation == md5_pkg::OP_ABSORB)
                    begin
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (pos_reg == md5_pkg::LAST_POS)
                        begin
                            final_next = 1'b0;
                            state_next = ST_PREP;
                        end
                    end
                    else
                    begin
                        len_next    = {count_reg, 3'b000};
                        len_ok_next = (pos_reg < md5_pkg::LEN_POS);
                        first_next  = 1'b1;
                        fin_next    = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                first_next = 1'b0;
                pos_next   = pos_reg + 6'd1;
                if (pos_reg == md5_pkg::LAST_POS)
                begin
                    final_next = len_ok_reg;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                a_next     = h0_reg;
                b_next     = h1_reg;
                c_next     = h2_reg;
                d_next     = h3_reg;
                step_next  = 6'd0;
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                a_next    = d_reg;
                d_next    = c_reg;
                c_next    = b_reg;
                b_next    = b_reg + md5_pkg::rotl32(t_val, md5_pkg::rot_amount(step_reg));
                step_next = step_reg + 6'd1;
                if (step_reg == md5_pkg::LAST_POS)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                h0_next = h0_reg + a_reg;
                h1_next = h1_reg + b_reg;
                h2_next = h2_reg + c_reg;
                h3_next = h3_reg + d_reg;
                if (final_reg)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                begin
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (digest_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        h0_next    = md5_pkg::IV_A;
                        h1_next    = md5_pkg::IV_B;
                        h2_next    = md5_pkg::IV_C;
                        h3_next    = md5_pkg::IV_D;
                        count_next = 61'd0;
                        fin_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= 6'd0;
            count_reg  <= 61'd0;
            len_ok_reg <= 1'b0;
            first_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            final_reg  <= 1'b0;
            step_reg   <= 6'd0;
            idx_reg    <= 2'd0;
            h0_reg     <= md5_pkg::IV_A;
            h1_reg     <= md5_pkg::IV_B;
            h2_reg     <= md5_pkg::IV_C;
            h3_reg     <= md5_pkg::IV_D;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            len_ok_reg <= len_ok_next;
            first_reg  <= first_next;
            fin_reg    <= fin_next;
            final_reg  <= final_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            h0_reg     <= h0_next;
            h1_reg     <= h1_next;
            h2_reg     <= h2_next;
            h3_reg     <= h3_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        asm_reg <= asm_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
    end

endmodule
